FILE: rtl/bof_pkg.sv
// ----------------------------------------------------------------------------
// bof_pkg
// Types, constants and helpers shared by the outline flattener modules.
// ----------------------------------------------------------------------------
package bof_pkg;

  localparam int CoordW = 24;
  localparam int TolW = 48;
  localparam int DefaultMaxDepth = 6;
  localparam logic [TolW-1:0] QuadTolReset = 48'd65536;
  localparam logic [TolW-1:0] CubicTolReset = 48'd16777216;

  typedef enum logic [1:0] {
    OP_MOVE  = 2'd0,
    OP_LINE  = 2'd1,
    OP_QUAD  = 2'd2,
    OP_CUBIC = 2'd3
  } op_t;

  localparam logic CFG_QUAD_TOL = 1'b0;
  localparam logic CFG_CUBIC_TOL = 1'b1;

  typedef logic signed [CoordW-1:0] coord_t;

  typedef struct packed {
    logic [1:0] operation;
    coord_t     first_x;
    coord_t     first_y;
    coord_t     second_x;
    coord_t     second_y;
    coord_t     third_x;
    coord_t     third_y;
  } bof_in_t;

  typedef struct packed {
    coord_t point_x;
    coord_t point_y;
    logic   starts_contour;
    logic   last;
  } bof_out_t;

  // controller to datapath
  typedef struct packed {
    logic load;     // capture input item, push root piece of a curve
    logic test;     // pop a piece into the working registers
    logic measure;  // register squared terms
    logic decide;   // compare, then split or emit
  } bof_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic flat;
    logic stack_empty;
  } bof_sts_t;

  function automatic coord_t half_floor(input coord_t a, input coord_t b);
    logic signed [CoordW:0] s;
    s = CoordW'(0) + {a[CoordW-1], a} + {b[CoordW-1], b};
    return s[CoordW:1];
  endfunction

endpackage

FILE: rtl/bof_datapath.sv
// ----------------------------------------------------------------------------
// bof_datapath
// Split stack, de Casteljau midpoints, flatness measure and result register.
// ----------------------------------------------------------------------------
module bof_datapath
  import bof_pkg::*;
#(
  parameter int MaxDepth = DefaultMaxDepth
) (
  input  logic            clk,
  input  logic            rst_n,
  input  bof_in_t         in_item,
  input  logic [TolW-1:0] quad_tol,
  input  logic [TolW-1:0] cubic_tol,
  input  bof_cmd_t        cmd,
  output bof_sts_t        sts,
  output bof_out_t        emit_item,
  output logic            emit
);

  localparam int Levels = MaxDepth + 1;
  localparam int SpW = $clog2(Levels + 1);
  localparam int LvlW = $clog2(MaxDepth + 1);
  localparam int SqW = 2 * (CoordW + 3);

  coord_t stk_x_r [Levels][4];
  coord_t stk_y_r [Levels][4];
  logic [LvlW-1:0] stk_lvl_r [Levels];
  logic [SpW-1:0] sp_r;
  logic cubic_r, single_r;
  coord_t cur_x_r, cur_y_r;
  coord_t x_r [4];
  coord_t y_r [4];
  logic [LvlW-1:0] lvl_r;
  logic [SqW-1:0] ax_r, ay_r;
  logic flat_w;
  bof_out_t emit_r;
  logic emit_v_r;

  // flatness terms from working registers
  logic signed [CoordW+2:0] ux, vx, uy, vy, dqx, dqy;
  logic [SqW-1:0] sux, svx, suy, svy;
  coord_t qlx, qly, qrx, qry, qbx, qby, qcx, qcy;
  always_comb begin
    ux = (CoordW+3)'(3 * (CoordW+3)'(x_r[1]) - 2 * (CoordW+3)'(x_r[0]) - (CoordW+3)'(x_r[3]));
    vx = (CoordW+3)'(3 * (CoordW+3)'(x_r[2]) - 2 * (CoordW+3)'(x_r[3]) - (CoordW+3)'(x_r[0]));
    uy = (CoordW+3)'(3 * (CoordW+3)'(y_r[1]) - 2 * (CoordW+3)'(y_r[0]) - (CoordW+3)'(y_r[3]));
    vy = (CoordW+3)'(3 * (CoordW+3)'(y_r[2]) - 2 * (CoordW+3)'(y_r[3]) - (CoordW+3)'(y_r[0]));
    qlx = half_floor(x_r[0], x_r[1]); qly = half_floor(y_r[0], y_r[1]);
    qrx = half_floor(x_r[1], x_r[2]); qry = half_floor(y_r[1], y_r[2]);
    qbx = half_floor(x_r[0], x_r[2]); qby = half_floor(y_r[0], y_r[2]);
    qcx = half_floor(qlx, qrx);       qcy = half_floor(qly, qry);
    dqx = (CoordW+3)'(qcx) - (CoordW+3)'(qbx);
    dqy = (CoordW+3)'(qcy) - (CoordW+3)'(qby);
    if (cubic_r) begin
      sux = SqW'($signed(ux) * $signed(ux));
      svx = SqW'($signed(vx) * $signed(vx));
      suy = SqW'($signed(uy) * $signed(uy));
      svy = SqW'($signed(vy) * $signed(vy));
    end else begin
      sux = SqW'($signed(dqx) * $signed(dqx));
      svx = '0;
      suy = SqW'($signed(dqy) * $signed(dqy));
      svy = '0;
    end
  end

  logic [SqW:0] meas;
  always_comb begin
    meas = {1'b0, ax_r} + {1'b0, ay_r};
    flat_w = (lvl_r >= LvlW'(MaxDepth)) ||
             (cubic_r ? (meas <= (SqW+1)'(cubic_tol)) : (meas <= (SqW+1)'(quad_tol)));
  end

  // split halves
  coord_t lx [4], ly [4], rx [4], ry [4];
  coord_t mx, my;
  always_comb begin
    mx = half_floor(x_r[1], x_r[2]); my = half_floor(y_r[1], y_r[2]);
    lx[0] = x_r[0]; ly[0] = y_r[0];
    lx[1] = half_floor(x_r[0], x_r[1]); ly[1] = half_floor(y_r[0], y_r[1]);
    if (cubic_r) begin
      rx[2] = half_floor(x_r[2], x_r[3]); ry[2] = half_floor(y_r[2], y_r[3]);
      rx[3] = x_r[3]; ry[3] = y_r[3];
      lx[2] = half_floor(lx[1], mx); ly[2] = half_floor(ly[1], my);
      rx[1] = half_floor(mx, rx[2]); ry[1] = half_floor(my, ry[2]);
      lx[3] = half_floor(lx[2], rx[1]); ly[3] = half_floor(ly[2], ry[1]);
      rx[0] = lx[3]; ry[0] = ly[3];
    end else begin
      rx[1] = mx; ry[1] = my;
      lx[2] = half_floor(lx[1], mx); ly[2] = half_floor(ly[1], my);
      rx[0] = lx[2]; ry[0] = ly[2];
      rx[2] = x_r[2]; ry[2] = y_r[2];
      lx[3] = '0; ly[3] = '0; rx[3] = '0; ry[3] = '0;
    end
  end

  logic [SpW-1:0] top;
  assign top = sp_r - SpW'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_r <= '0;
      cur_x_r <= '0;
      cur_y_r <= '0;
      emit_v_r <= 1'b0;
      single_r <= 1'b0;
    end else begin
      emit_v_r <= 1'b0;
      if (cmd.load) begin
        cubic_r <= (in_item.operation == OP_CUBIC);
        single_r <= (in_item.operation == OP_MOVE) || (in_item.operation == OP_LINE);
        stk_x_r[0][0] <= cur_x_r; stk_y_r[0][0] <= cur_y_r;
        stk_x_r[0][1] <= in_item.first_x; stk_y_r[0][1] <= in_item.first_y;
        stk_x_r[0][2] <= in_item.second_x; stk_y_r[0][2] <= in_item.second_y;
        stk_x_r[0][3] <= (in_item.operation == OP_CUBIC) ? in_item.third_x : '0;
        stk_y_r[0][3] <= (in_item.operation == OP_CUBIC) ? in_item.third_y : '0;
        stk_lvl_r[0] <= '0;
        unique case (op_t'(in_item.operation))
          OP_MOVE, OP_LINE: begin
            cur_x_r <= in_item.first_x; cur_y_r <= in_item.first_y;
            sp_r <= '0;
            emit_r <= '{point_x: in_item.first_x, point_y: in_item.first_y,
                        starts_contour: (in_item.operation == OP_MOVE), last: 1'b1};
            emit_v_r <= 1'b1;
          end
          OP_QUAD: begin
            cur_x_r <= in_item.second_x; cur_y_r <= in_item.second_y;
            sp_r <= SpW'(1);
          end
          default: begin
            cur_x_r <= in_item.third_x; cur_y_r <= in_item.third_y;
            sp_r <= SpW'(1);
          end
        endcase
      end
      if (cmd.test) begin
        for (int k = 0; k < 4; k++) begin
          x_r[k] <= stk_x_r[top[SpW-1:0] < SpW'(Levels) ? top : '0][k];
          y_r[k] <= stk_y_r[top < SpW'(Levels) ? top : '0][k];
        end
        lvl_r <= stk_lvl_r[top < SpW'(Levels) ? top : '0];
        sp_r <= top;
      end
      if (cmd.measure) begin
        ax_r <= (sux < svx) ? svx : sux;
        ay_r <= (suy < svy) ? svy : suy;
      end
      if (cmd.decide) begin
        if (flat_w) begin
          emit_r <= '{point_x: cubic_r ? x_r[3] : x_r[2],
                      point_y: cubic_r ? y_r[3] : y_r[2],
                      starts_contour: 1'b0, last: (sp_r == '0)};
          emit_v_r <= 1'b1;
        end else begin
          for (int k = 0; k < 4; k++) begin
            stk_x_r[sp_r][k] <= rx[k]; stk_y_r[sp_r][k] <= ry[k];
            stk_x_r[sp_r + SpW'(1)][k] <= lx[k]; stk_y_r[sp_r + SpW'(1)][k] <= ly[k];
          end
          stk_lvl_r[sp_r] <= lvl_r + LvlW'(1);
          stk_lvl_r[sp_r + SpW'(1)] <= lvl_r + LvlW'(1);
          sp_r <= sp_r + SpW'(2);
        end
      end
    end
  end

  assign sts.flat = flat_w;
  assign sts.stack_empty = (sp_r == '0) || single_r;
  assign emit_item = emit_r;
  assign emit = emit_v_r;

  property p_sp_bound;
    @(posedge clk) disable iff (!rst_n) sp_r <= SpW'(Levels);
  endproperty
  a_sp_bound: assert property (p_sp_bound) else $error("split stack overflow");

  property p_emit_from_cmd;
    @(posedge clk) disable iff (!rst_n) emit_v_r |-> $past(cmd.load || cmd.decide);
  endproperty
  a_emit_from_cmd: assert property (p_emit_from_cmd) else $error("stray emit");

  property p_move_single;
    @(posedge clk) disable iff (!rst_n)
      (emit_v_r && emit_r.starts_contour) |-> emit_r.last;
  endproperty
  a_move_single: assert property (p_move_single) else $error("move not last");

endmodule

FILE: rtl/bof_ctrl.sv
// ----------------------------------------------------------------------------
// bof_ctrl
// Sequencer that walks the split stack: pop, measure, decide, hand off result.
// ----------------------------------------------------------------------------
module bof_ctrl
  import bof_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  logic     emit,
  input  bof_out_t emit_item,
  output bof_out_t out_item,
  output logic     out_valid,
  input  logic     out_stall,
  output bof_cmd_t cmd,
  input  bof_sts_t sts
);

  typedef enum logic [2:0] {S_IDLE, S_START, S_POP, S_MEAS, S_DEC, S_HOLD} state_t;

  state_t state_r, state_nxt;
  bof_out_t out_r;
  logic out_v_r;

  assign in_stall = (state_r != S_IDLE) || out_v_r;
  assign out_item = out_r;
  assign out_valid = out_v_r;

  always_comb begin
    cmd = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_valid && !in_stall) begin
        cmd.load = 1'b1;
        state_nxt = S_START;
      end
      S_START: state_nxt = sts.stack_empty ? S_HOLD : S_POP;
      S_POP: if (!out_v_r || !out_stall) begin
        cmd.test = 1'b1;
        state_nxt = S_MEAS;
      end
      S_MEAS: begin
        cmd.measure = 1'b1;
        state_nxt = S_DEC;
      end
      S_DEC: begin
        cmd.decide = 1'b1;
        state_nxt = S_HOLD;
      end
      S_HOLD: state_nxt = S_START;
      default: state_nxt = S_IDLE;
    endcase
    if (state_r == S_START && sts.stack_empty) state_nxt = S_IDLE;
    if (state_r == S_HOLD) state_nxt = S_START;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (emit) begin
        out_r <= emit_item;
        out_v_r <= 1'b1;
      end else if (out_v_r && !out_stall) begin
        out_v_r <= 1'b0;
      end
    end
  end

  property p_no_overwrite;
    @(posedge clk) disable iff (!rst_n) emit |-> (!$past(out_v_r) || !$past(out_stall));
  endproperty
  a_no_overwrite: assert property (p_no_overwrite) else $error("result overwritten");

  property p_busy_stall;
    @(posedge clk) disable iff (!rst_n) (state_r != S_IDLE) |-> in_stall;
  endproperty
  a_busy_stall: assert property (p_busy_stall) else $error("accept while busy");

  property p_one_cmd;
    @(posedge clk) disable iff (!rst_n) $onehot0(cmd);
  endproperty
  a_one_cmd: assert property (p_one_cmd) else $error("multiple commands");

endmodule

FILE: rtl/bezier_outline_flattener.sv
// ----------------------------------------------------------------------------
// bezier_outline_flattener
// Move, line, quadratic and cubic outline commands in, outline vertices out.
// ----------------------------------------------------------------------------
// Move and line emit one vertex. A curve walks a split
// stack of MAX_DEPTH+1 pieces, one piece at a time (check, pop,
// measure, compare, hand off); a curve split to depth d visits 2^(d+1)-1
// pieces, so up to 127 pieces at MAX_DEPTH 6. The sequencer also waits
// on a stalled result register before popping the next piece.
module bezier_outline_flattener
  import bof_pkg::*;
#(
  parameter int MAX_DEPTH = DefaultMaxDepth
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  bof_in_t         in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output bof_out_t        out_data,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic            cfg_index,
  input  logic [TolW-1:0] cfg_data
);

  logic [TolW-1:0] quad_tol_r, cubic_tol_r;
  bof_cmd_t cmd;
  bof_sts_t sts;
  bof_out_t emit_item;
  logic emit;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quad_tol_r <= QuadTolReset;
      cubic_tol_r <= CubicTolReset;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_QUAD_TOL: quad_tol_r <= cfg_data;
        CFG_CUBIC_TOL: cubic_tol_r <= cfg_data;
        default: ;
      endcase
    end
  end

  bof_datapath #(.MaxDepth(MAX_DEPTH)) u_dp (
    .clk, .rst_n, .in_item(in_data), .quad_tol(quad_tol_r), .cubic_tol(cubic_tol_r),
    .cmd, .sts, .emit_item, .emit
  );

  bof_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .emit, .emit_item,
    .out_item(out_data), .out_valid, .out_stall, .cmd, .sts
  );

endmodule
